>>> src/nsf_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence checksum framer.
package nsf_pkg;

  localparam int unsigned RING_DEPTH_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  CH_DOLLAR        = 8'h24;
  localparam logic [7:0]  CH_STAR          = 8'h2A;
  localparam logic [7:0]  CH_ZERO          = 8'h30;
  localparam logic [7:0]  CH_NINE          = 8'h39;
  localparam logic [15:0] HEX_ALPHA_OFFSET = 16'h0037;
  localparam logic [15:0] WORD_GOOD        = 16'h002A;
  localparam logic [15:0] BAD_MARK         = 16'hFF00;
  localparam logic [15:0] WORD_ETX         = 16'h0003;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic       close;   // 1: flag write plus end marker, 0: payload write
    logic [7:0] addr;    // payload slot, or the reserved flag slot
    logic [7:0] data;    // payload byte
    logic [7:0] addr2;   // end-marker slot
    logic       good;    // checksum verdict
  } cmd_t;

  // Checksum character to its digit value, modulo 2^16.
  function automatic logic [15:0] digit_value(input logic [7:0] c);
    logic [15:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {8'h00, c} - {8'h00, CH_ZERO};
    end else begin
      v = {8'h00, c} - HEX_ALPHA_OFFSET;
    end
    return v;
  endfunction

endpackage

>>> src/nsf_front.sv
// Front end: accepts bytes, tracks sentence phase and checksum, issues ring commands.
module nsf_front #(
  parameter int unsigned RING_DEPTH = nsf_pkg::RING_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          q_full,
  output logic          push,
  output nsf_pkg::cmd_t push_cmd
);
  import nsf_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_DIGITS
  } phase_t;

  phase_t        phase;
  logic [7:0]    running_xor;
  logic [15:0]   received_sum;
  logic          hex_digit_count;
  logic [PW-1:0] write_pointer;
  logic [PW-1:0] flag_slot;

  logic          accept;
  logic [PW-1:0] ptr_next;
  logic [15:0]   sum_next;
  logic          good;
  logic [PW+7:0] ptr_ext;
  logic [PW+7:0] flag_ext;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign ptr_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + PW'(1);
  assign sum_next = {received_sum[11:0], 4'h0} + digit_value(s_tdata);
  assign good     = ({8'h00, running_xor} == sum_next);
  assign ptr_ext  = (PW + 8)'(write_pointer);
  assign flag_ext = (PW + 8)'(flag_slot);

  always_comb begin
    push           = 1'b0;
    push_cmd.close = 1'b0;
    push_cmd.addr  = ptr_ext[7:0];
    push_cmd.data  = s_tdata;
    push_cmd.addr2 = ptr_ext[7:0];
    push_cmd.good  = good;
    if (accept) begin
      case (phase)
        PH_PAYLOAD: push = (s_tdata != CH_STAR);
        PH_DIGITS: begin
          if (hex_digit_count) begin
            push           = 1'b1;
            push_cmd.close = 1'b1;
            push_cmd.addr  = flag_ext[7:0];
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      running_xor     <= '0;
      received_sum    <= '0;
      hex_digit_count <= 1'b0;
      write_pointer   <= '0;
      flag_slot       <= '0;
    end else if (accept) begin
      case (phase)
        PH_PAYLOAD: begin
          if (s_tdata == CH_STAR) begin
            phase <= PH_DIGITS;
          end else begin
            running_xor   <= running_xor ^ s_tdata;
            write_pointer <= ptr_next;
          end
        end
        PH_DIGITS: begin
          received_sum <= sum_next;
          if (!hex_digit_count) begin
            hex_digit_count <= 1'b1;
          end else begin
            hex_digit_count <= 1'b0;
            write_pointer   <= ptr_next;
            phase           <= PH_HUNT;
          end
        end
        default: begin
          phase <= PH_HUNT;
          if (s_tdata == CH_DOLLAR) begin
            running_xor     <= '0;
            received_sum    <= '0;
            hex_digit_count <= 1'b0;
            flag_slot       <= write_pointer;
            write_pointer   <= ptr_next;
            phase           <= PH_PAYLOAD;
          end
        end
      endcase
    end
  end

endmodule

>>> src/nsf_queue.sv
// Small register FIFO that decouples the front end from the back end.
module nsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nsf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output nsf_pkg::cmd_t head_cmd
);
  import nsf_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QW-1:0] Q_LAST = QW'(QUEUE_DEPTH - 1);

  cmd_t        entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == (QW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_LAST) ? '0 : wr_ptr + QW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_LAST) ? '0 : rd_ptr + QW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QW + 1)'(1);
        2'b01:   count <= count - (QW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/nsf_back.sv
// Back end: turns queued commands into registered ring-write transactions.
module nsf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  nsf_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,
  output logic          m_tlast
);
  import nsf_pkg::*;

  typedef enum logic {
    ST_FIRST,
    ST_SECOND
  } state_t;

  state_t     state;
  logic [7:0] etx_addr;
  logic       etx_good;
  logic       out_free;
  logic [15:0] flag_word;

  assign out_free  = !m_tvalid || m_tready;
  assign pop       = out_free && (state == ST_FIRST) && head_valid;
  assign flag_word = head_cmd.good ? WORD_GOOD : (WORD_GOOD | BAD_MARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FIRST;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tlast  <= 1'b0;
      etx_addr <= '0;
      etx_good <= 1'b0;
    end else if (out_free) begin
      case (state)
        ST_SECOND: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'b0, etx_good, 1'b1, WORD_ETX, etx_addr};
          m_tlast  <= 1'b1;
          state    <= ST_FIRST;
        end
        default: begin
          m_tvalid <= head_valid;
          if (head_valid) begin
            if (head_cmd.close) begin
              m_tdata  <= {6'b0, head_cmd.good, 1'b1, flag_word, head_cmd.addr};
              m_tlast  <= 1'b0;
              etx_addr <= head_cmd.addr2;
              etx_good <= head_cmd.good;
              state    <= ST_SECOND;
            end else begin
              m_tdata <= {6'b0, 1'b0, 1'b0, 8'h00, head_cmd.data, head_cmd.addr};
              m_tlast <= 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> src/nmea_sentence_checksum_framer.sv
// Top level of the NMEA sentence checksum framer: front end, command queue, back end.
// A byte that causes a write passes the command queue and the back end's output register.
// Throughput: one byte per cycle while the queue is not full; a closing byte yields two
// ring writes; the back end emits one per cycle when not stalled, from a two-entry queue.
// Reset (rst, synchronous, active high) returns to hunting with pointer, slot and sums zero,
// and empties the queue and the output register.
module nmea_sentence_checksum_framer #(
  parameter int unsigned RING_DEPTH = nsf_pkg::RING_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Input transaction: one received character.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Output transaction: one ring write.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] write_address, [23:8] write_word,
                                 // [24] sentence_done, [25] checksum_good, [31:26] zero
  output logic        m_tlast    // last write caused by the input byte
);
  import nsf_pkg::*;

  // The front end owns all sentence state: phase, running XOR, received sum,
  // write pointer and the reserved flag slot. It turns each accepted byte into
  // at most one command. It stalls only when the queue is full.
  logic q_full;
  logic push;
  cmd_t push_cmd;

  // The queue lets the back end emit both writes of a closing command while
  // the front end keeps taking bytes.
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  nsf_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // The back end holds the output register: a payload command becomes one
  // transaction, a closing command becomes the flag write into the reserved
  // slot followed by the end marker after the payload.
  nsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

>>> bench/nmea_framer_write_checker.sv
// Checker for the NMEA framer: predicts every ring write from accepted bytes and compares.
module nmea_framer_write_checker #(
  parameter int unsigned RING_DEPTH = nsf_pkg::RING_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_writes
);
  import nsf_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    FRAME_HUNT,
    FRAME_PAYLOAD,
    FRAME_DIGITS
  } frame_phase_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] word;
    logic        done;
    logic        good;
    logic        last;
  } ring_write_t;

  // Predicted framer state.
  frame_phase_t  frame_phase;
  logic [7:0]    sentence_xor;
  logic [15:0]   checksum_field;
  logic          second_digit;
  int unsigned   ring_ptr;
  int unsigned   status_slot;

  ring_write_t   expected_writes[$];
  int            mismatches;

  function automatic int unsigned ring_advance(input int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Checksum characters: decimal digits map by '0', everything else by the
  // alpha offset, with 16-bit wrap so junk characters give large values.
  function automatic logic [15:0] checksum_char_value(input logic [7:0] c);
    logic [15:0] wide;
    wide = {8'h00, c};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return wide - {8'h00, CH_ZERO};
    end
    return wide - HEX_ALPHA_OFFSET;
  endfunction

  task automatic predict_byte(input logic [7:0] c);
    ring_write_t w;
    logic        ok;
    case (frame_phase)
      FRAME_PAYLOAD: begin
        if (c == CH_STAR) begin
          frame_phase = FRAME_DIGITS;
        end else begin
          w = '{addr: ring_ptr[7:0], word: {8'h00, c}, done: 1'b0, good: 1'b0, last: 1'b1};
          expected_writes.push_back(w);
          sentence_xor = sentence_xor ^ c;
          ring_ptr = ring_advance(ring_ptr);
        end
      end
      FRAME_DIGITS: begin
        checksum_field = (checksum_field << 4) + checksum_char_value(c);
        if (!second_digit) begin
          second_digit = 1'b1;
        end else begin
          second_digit = 1'b0;
          ok = ({8'h00, sentence_xor} == checksum_field);
          w = '{addr: status_slot[7:0], word: ok ? WORD_GOOD : (WORD_GOOD | BAD_MARK),
                done: 1'b1, good: ok, last: 1'b0};
          expected_writes.push_back(w);
          w = '{addr: ring_ptr[7:0], word: WORD_ETX, done: 1'b1, good: ok, last: 1'b1};
          expected_writes.push_back(w);
          ring_ptr = ring_advance(ring_ptr);
          frame_phase = FRAME_HUNT;
        end
      end
      default: begin
        frame_phase = FRAME_HUNT;
        if (c == CH_DOLLAR) begin
          sentence_xor = '0;
          checksum_field = '0;
          second_digit = 1'b0;
          status_slot = ring_ptr;
          ring_ptr = ring_advance(ring_ptr);
          frame_phase = FRAME_PAYLOAD;
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      end
    end
  endtask

  initial begin
    mismatches = 0;
    fail_count = 0;
    pending_writes = 0;
  end

  always @(posedge clk) begin
    ring_write_t w;
    if (rst) begin
      frame_phase = FRAME_HUNT;
      sentence_xor = '0;
      checksum_field = '0;
      second_digit = 1'b0;
      ring_ptr = 0;
      status_slot = 0;
      expected_writes.delete();
    end else begin
      // Retire the oldest expectation first; a write never leaves in the
      // same cycle as the byte that causes it.
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $error("unexpected ring write: tdata 0x%0h tlast %0b", m_tdata, m_tlast);
          end
        end else begin
          w = expected_writes.pop_front();
          check_field("write_address", 32'(w.addr), 32'(m_tdata[7:0]));
          check_field("write_word", 32'(w.word), 32'(m_tdata[23:8]));
          check_field("sentence_done", 32'(w.done), 32'(m_tdata[24]));
          check_field("checksum_good", 32'(w.good), 32'(m_tdata[25]));
          check_field("tdata padding", 32'(0), 32'(m_tdata[31:26]));
          check_field("last", 32'(w.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata);
      end
    end
    fail_count <= mismatches;
    pending_writes <= expected_writes.size();
  end

endmodule

>>> bench/nmea_sentence_checksum_framer_tb.sv
// Testbench top for the NMEA sentence checksum framer: clock, reset, byte stimulus, verdict.
module nmea_sentence_checksum_framer_tb;
  import nsf_pkg::*;

  localparam logic [7:0] CH_UPPER_A     = 8'h41;
  localparam logic [7:0] CH_LOWER_A     = 8'h61;
  localparam int         SENTENCE_BYTES = 450;
  localparam int         SETTLE_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  int          fail_count;
  int          pending_writes;

  // When set, the corresponding side runs at full rate with no idle cycles.
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;
  int          sentence_bytes = 0;

  // Directed prologue: hunting noise at both byte extremes, a good sentence,
  // a bad one, a sentence with a dollar sign and extreme bytes inside its
  // payload and an all-letter checksum, and an empty sentence whose
  // checksum characters are not hex at all (one wraps below zero).
  logic [7:0]  directed_bytes[] = '{
    8'h00, 8'hFF,
    CH_DOLLAR, "G", "P", CH_STAR, "1", "7",
    CH_DOLLAR, "A", CH_STAR, "0", "0",
    CH_DOLLAR, 8'h00, CH_DOLLAR, 8'hFF, CH_STAR, "D", "B",
    CH_DOLLAR, CH_STAR, "z", 8'h00
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  nmea_sentence_checksum_framer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  nmea_framer_write_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .pending_writes (pending_writes)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_idle(input bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 10) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit lower);
    if (nibble < 4'd10) begin
      return CH_ZERO + {4'h0, nibble};
    end
    return (lower ? CH_LOWER_A : CH_UPPER_A) + {4'h0, nibble} - 8'd10;
  endfunction

  // Offers one byte and returns at the edge where the transaction completes.
  // Valid stays high between back-to-back bytes so it is never dropped and
  // raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    int idle;
    idle = pick_idle(steady_in);
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds the input off until the checker has seen every predicted write.
  // The first edge lets the checker's count catch up with the last byte.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
  endtask

  // One sentence with random content. Most are well formed with a correct
  // checksum; some carry a lowercase or random checksum, and a few are cut
  // short so the next dollar sign lands inside the payload.
  task automatic send_sentence();
    int          len;
    int          mode;
    logic [7:0]  b;
    logic [7:0]  xor_acc;
    bit          truncated;
    len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 60);
    truncated = ($urandom_range(0, 11) == 0);
    xor_acc = '0;
    send_byte(CH_DOLLAR);
    sentence_bytes++;
    for (int i = 0; i < len; i++) begin
      do begin
        b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                        : 8'($urandom_range(0, 255));
      end while (b == CH_STAR);
      xor_acc ^= b;
      send_byte(b);
      sentence_bytes++;
    end
    if (!truncated) begin
      send_byte(CH_STAR);
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        send_byte(hex_char(xor_acc[7:4], 1'b0));
        send_byte(hex_char(xor_acc[3:0], 1'b0));
      end else if (mode == 7) begin
        send_byte(hex_char(xor_acc[7:4], 1'b1));
        send_byte(hex_char(xor_acc[3:0], 1'b1));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
      sentence_bytes += 3;
    end
  endtask

  // Output side: m_tready holds each level for a random run, most runs
  // short and some long, with full-rate stretches when steady_out is set.
  initial begin
    int   hold;
    logic level;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        if (steady_out) begin
          level = 1'b1;
          hold = 1;
        end else begin
          level = ($urandom_range(0, 2) != 0);
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        m_tready <= level;
      end
      hold--;
    end
  end

  // Input side and verdict.
  initial begin
    int noise;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i]);
    end
    wait_drained();

    while (sentence_bytes < SENTENCE_BYTES) begin
      if ($urandom_range(0, 5) == 0) steady_in = !steady_in;
      if ($urandom_range(0, 5) == 0) steady_out = !steady_out;
      // Line noise between sentences; a stray dollar sign here starts a
      // sentence early, which the checker follows like any other.
      noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (noise) send_byte(8'($urandom_range(0, 255)));
      send_sentence();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
